// File: src/sidl_pkg.sv
// sidl_pkg: shared types and constants for the sorted id index lookup unit.
// Holds command codes, request/response words, FSM states and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package sidl_pkg;

  // Fixed field widths of the request and response words
  localparam int KEY_W = 31;
  localparam int CMD_W = 2;
  localparam int POS_W = 10;
  localparam int CNT_W = 11;

  // Command codes (code 3 is unused and leaves the table alone)
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Request word
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
  } req_t;

  // Response word
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             full_res;
    logic [CNT_W-1:0] count;
  } rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SRCH,
    ST_CMP,
    ST_CHK,
    ST_SHIFT,
    ST_SHIFT_WR
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch request, init search bounds and shift index
    logic srch_rd;   // read the probe slot (mid)
    logic srch_upd;  // narrow search bounds from the probe word
    logic chk_rd;    // read the lower-bound slot for the hit check
    logic shift_rd;  // read the slot below the shift index
    logic shift_wr;  // move that word up one slot
    logic insert;    // write the new key at the insertion slot
    logic done;      // register the response word and strobe it
    logic use_hit;   // response may report a hit from the read word
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             lo_lt_hi;
    logic             lo_lt_cnt;
    logic             idx_eq_lo;
  } dp_sts_t;

endpackage

// File: src/sidl_ram.sv
// sidl_ram: generic simple dual-port RAM, one write and one read port,
// read data registered. No dependencies.
`timescale 1ns / 1ps

module sidl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/sidl_ctrl.sv
// sidl_ctrl: controller FSM sequencing clear, append (search, shift,
// insert) and lookup (search, check). Depends on sidl_pkg.
`timescale 1ns / 1ps

module sidl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sidl_pkg::dp_sts_t sts_i,
  output sidl_pkg::dp_cmd_t cmd_o,
  output logic              busy_o
);

  sidl_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sidl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sidl_pkg::ST_IDLE: begin
        if (start_i) state_d = sidl_pkg::ST_DISPATCH;
      end
      sidl_pkg::ST_DISPATCH: begin
        if ((sts_i.cmd == sidl_pkg::CMD_APPEND && !sts_i.full) ||
            sts_i.cmd == sidl_pkg::CMD_LOOKUP) begin
          state_d = sidl_pkg::ST_SRCH;
        end else begin
          state_d = sidl_pkg::ST_IDLE;
        end
      end
      sidl_pkg::ST_SRCH: begin
        if (sts_i.lo_lt_hi) begin
          state_d = sidl_pkg::ST_CMP;
        end else if (sts_i.cmd == sidl_pkg::CMD_APPEND) begin
          state_d = sidl_pkg::ST_SHIFT;
        end else if (sts_i.lo_lt_cnt) begin
          state_d = sidl_pkg::ST_CHK;
        end else begin
          state_d = sidl_pkg::ST_IDLE;
        end
      end
      sidl_pkg::ST_CMP:      state_d = sidl_pkg::ST_SRCH;
      sidl_pkg::ST_CHK:      state_d = sidl_pkg::ST_IDLE;
      sidl_pkg::ST_SHIFT: begin
        if (sts_i.idx_eq_lo) begin
          state_d = sidl_pkg::ST_IDLE;
        end else begin
          state_d = sidl_pkg::ST_SHIFT_WR;
        end
      end
      sidl_pkg::ST_SHIFT_WR: state_d = sidl_pkg::ST_SHIFT;
      default:               state_d = sidl_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != sidl_pkg::ST_IDLE);
    unique case (state_q)
      sidl_pkg::ST_IDLE: begin
        cmd_o.load = start_i;
      end
      sidl_pkg::ST_DISPATCH: begin
        // clear, unused code and append on a full table finish here
        if (!((sts_i.cmd == sidl_pkg::CMD_APPEND && !sts_i.full) ||
              sts_i.cmd == sidl_pkg::CMD_LOOKUP)) begin
          cmd_o.done = 1'b1;
        end
      end
      sidl_pkg::ST_SRCH: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.srch_rd = 1'b1;
        end else if (sts_i.cmd == sidl_pkg::CMD_APPEND) begin
          cmd_o = '0;
        end else if (sts_i.lo_lt_cnt) begin
          cmd_o.chk_rd = 1'b1;
        end else begin
          // lookup ran past the last entry: miss
          cmd_o.done = 1'b1;
        end
      end
      sidl_pkg::ST_CMP: begin
        cmd_o.srch_upd = 1'b1;
      end
      sidl_pkg::ST_CHK: begin
        cmd_o.done    = 1'b1;
        cmd_o.use_hit = 1'b1;
      end
      sidl_pkg::ST_SHIFT: begin
        if (sts_i.idx_eq_lo) begin
          cmd_o.insert = 1'b1;
          cmd_o.done   = 1'b1;
        end else begin
          cmd_o.shift_rd = 1'b1;
        end
      end
      sidl_pkg::ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: src/sidl_dpath.sv
// sidl_dpath: datapath of the lookup unit: request registers, search
// bounds, shift index, sorted entry RAM and response register.
// Depends on sidl_pkg and sidl_ram.
`timescale 1ns / 1ps

module sidl_dpath #(
  parameter int ENTRIES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sidl_pkg::req_t    req_i,
  input  sidl_pkg::dp_cmd_t cmd_i,
  output sidl_pkg::dp_sts_t sts_o,
  output sidl_pkg::rsp_t    rsp_o,
  output logic              done_o
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int DW = sidl_pkg::KEY_W + AW;
  localparam int PW = (AW > sidl_pkg::POS_W) ? AW : sidl_pkg::POS_W;
  localparam int QW = (CW > sidl_pkg::CNT_W) ? CW : sidl_pkg::CNT_W;

  logic [sidl_pkg::CMD_W-1:0] cmd_q;
  logic [sidl_pkg::KEY_W-1:0] key_q;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              lo_q, hi_q, idx_q;
  logic [CW-1:0]              mid, idx_m1;
  sidl_pkg::rsp_t             rsp_q, rsp_d;
  logic                       done_q;

  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  logic [DW-1:0]              wdata, rdata;
  logic [sidl_pkg::KEY_W-1:0] rd_key;
  logic [AW-1:0]              rd_pos;
  logic                       go_right, hit;
  logic [PW-1:0]              pos_ext;
  logic [QW-1:0]              cnt_ext;

  // sorted entries: {key, load position}, ordered by key then position
  sidl_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_sorted_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // search probe and compare
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_m1   = idx_q - CW'(1);
  assign rd_key   = rdata[DW-1:AW];
  assign rd_pos   = rdata[AW-1:0];
  // append looks for the upper bound, lookup for the lower bound
  assign go_right = (cmd_q == sidl_pkg::CMD_APPEND) ? (rd_key <= key_q) : (rd_key < key_q);
  assign hit      = cmd_i.use_hit && (rd_key == key_q);

  // RAM address and write muxing
  always_comb begin
    if (cmd_i.chk_rd) begin
      raddr = lo_q[AW-1:0];
    end else if (cmd_i.shift_rd) begin
      raddr = idx_m1[AW-1:0];
    end else if (cmd_i.srch_rd) begin
      raddr = mid[AW-1:0];
    end else begin
      raddr = '0;
    end
    we    = cmd_i.shift_wr || cmd_i.insert;
    waddr = cmd_i.insert ? lo_q[AW-1:0] : idx_q[AW-1:0];
    wdata = cmd_i.insert ? {key_q, count_q[AW-1:0]} : rdata;
  end

  // request, bounds and shift index registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key;
      lo_q  <= '0;
      hi_q  <= count_q;
      idx_q <= count_q;
    end else begin
      if (cmd_i.srch_upd) begin
        if (go_right) begin
          lo_q <= mid + CW'(1);
        end else begin
          hi_q <= mid;
        end
      end
      if (cmd_i.shift_wr) begin
        idx_q <= idx_m1;
      end
    end
  end

  // response word and count update
  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    pos_ext = '0;
    cnt_ext = QW'(count_q);
    case (cmd_q)
      sidl_pkg::CMD_CLEAR: begin
        count_d = '0;
        cnt_ext = '0;
      end
      sidl_pkg::CMD_APPEND: begin
        if (count_q == CW'(ENTRIES)) begin
          rsp_d.full_res = 1'b1;
        end else begin
          count_d = count_q + CW'(1);
          pos_ext = PW'(count_q[AW-1:0]);
          cnt_ext = QW'(count_d);
        end
      end
      sidl_pkg::CMD_LOOKUP: begin
        rsp_d.found = hit;
        if (hit) begin
          pos_ext = PW'(rd_pos);
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
    rsp_d.position = pos_ext[sidl_pkg::POS_W-1:0];
    rsp_d.count    = cnt_ext[sidl_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      rsp_q <= rsp_d;
    end
  end

  // control state: entry count and response strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.done;
      if (cmd_i.done) begin
        count_q <= count_d;
      end
    end
  end

  // status to the controller
  assign sts_o.cmd       = cmd_q;
  assign sts_o.full      = (count_q == CW'(ENTRIES));
  assign sts_o.lo_lt_hi  = (lo_q < hi_q);
  assign sts_o.lo_lt_cnt = (lo_q < count_q);
  assign sts_o.idx_eq_lo = (idx_q == lo_q);

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

// File: src/sorted_id_index_lookup_unit.sv
// Sorted id index lookup unit: one word in, one response word out, one at a time;
// the next word is taken at the end of the cycle in which done_o strobes.
// Lookup: binary search over the n entries held, each probe a read on the
// registered RAM read port, then a hit check of the lower-bound slot if filled.
// Append: search as above, entries moved up one slot each to make room (up to
// n), then insert. Clear, unused code and append when full end at dispatch.
// Reset empties the table at once (count to 0, no sweep); done_o strobes 1 cycle.
`timescale 1ns / 1ps

module sorted_id_index_lookup_unit #(
  parameter int ENTRIES = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  sidl_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output sidl_pkg::rsp_t rsp_o
);

  sidl_pkg::dp_cmd_t dp_cmd;
  sidl_pkg::dp_sts_t dp_sts;

  // sequencing
  sidl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (dp_sts),
    .cmd_o   (dp_cmd),
    .busy_o  (busy_o)
  );

  // storage and compare
  sidl_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule
